@@ src/assert_macros.svh @@
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FRIC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FRIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fric_pkg.sv @@
// shared types, widths and constants of the bed-friction velocity update
package fric_pkg;

    localparam int VEL_W      = 24;
    localparam int DEPTH_W    = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int GRAV_W     = 24;
    localparam int SLOPE_W    = 24;
    localparam int COEF_W     = 32;

    localparam int PART_W     = 16;                 // half of a 32-bit coefficient
    localparam int SQ_W       = 47;                 // u*u is at most 2^46
    localparam int PP_W       = SQ_W + PART_W;      // partial product width
    localparam int MAG_W      = PP_W - PART_W;      // clamped accel magnitude
    localparam int INC_W      = MAG_W + 1;          // signed velocity increment
    localparam int FRIC_SHIFT = 3;                  // times 8 before the depth divide
    localparam int F_W        = SQ_W + FRIC_SHIFT - 1;

    localparam int DIV_NUM_W  = 52;
    localparam int DIV_REM_W  = DEPTH_W + 1;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_BITS;

    localparam int ACC_W      = 52;
    localparam int GPROD_W    = GRAV_W + SLOPE_W + 1;
    localparam int GS_SHIFT   = 20;
    localparam int GS_W       = 28;
    localparam int SUM_W      = 52;

    localparam logic [MAG_W-1:0] ACC_LIM = '1;

    // divide by three: n * ceil(2^29 / 3) >> 29 is exact for n < 2^29
    localparam int DIV3_IN_W    = 25;
    localparam int RECIP3_W     = 28;
    localparam int RECIP3_SHIFT = 29;
    localparam int DIV3_PROD_W  = DIV3_IN_W + RECIP3_W;
    localparam logic [RECIP3_W-1:0] RECIP3 = 28'd178956971;
    localparam logic signed [SUM_W-1:0] DIV3_HI = SUM_W'(25165824);
    localparam logic signed [SUM_W-1:0] DIV3_LO = SUM_W'(-25165827);

    localparam logic [COEF_W-1:0]         CF_RESET    = 32'd33775700;
    localparam logic [GRAV_W-1:0]         G_RESET     = 24'd642908;
    localparam logic signed [SLOPE_W-1:0] SLOPE_RESET = 24'sd1414148;
    localparam logic [COEF_W-1:0]         DT_RESET    = 32'd0;

    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRICTION_COEFF = 8'd0,
        REG_GRAVITY        = 8'd1,
        REG_BED_SLOPE      = 8'd2,
        REG_TIME_STEP      = 8'd3
    } reg_idx_t;

    typedef logic signed [VEL_W-1:0] vel_t;

    typedef struct packed {
        vel_t               u0;
        vel_t               u1;
        vel_t               u2;
        logic [DEPTH_W-1:0] depth;
        logic               sat;
        logic               dry;
    } side_t;

    typedef struct packed {
        side_t side;
        logic  neg;
    } div_tag_t;

    typedef struct packed {
        logic [COEF_W-1:0]      cf;
        logic [COEF_W-1:0]      dt;
        logic signed [GS_W-1:0] gs;
    } coef_t;

    typedef struct packed {
        vel_t v;
        logic sat;
    } sat_t;

    function automatic sat_t sat_vel(input logic signed [SUM_W-1:0] v);
        sat_t r;
        logic ovf;
        ovf = !((&v[SUM_W-1:VEL_W-1]) || !(|v[SUM_W-1:VEL_W-1]));
        r.sat = ovf;
        if (ovf)
        begin
            r.v = v[SUM_W-1] ? VEL_MIN : VEL_MAX;
        end
        else
        begin
            r.v = v[VEL_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/fric_div.sv @@
// pipelined restoring divider, a few quotient bits per stage
module fric_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [fric_pkg::DIV_NUM_W-1:0]   num,
    input  logic [fric_pkg::DEPTH_W-1:0]     den,
    input  fric_pkg::div_tag_t               tag_in,
    output logic                             out_valid,
    output logic [fric_pkg::DIV_NUM_W-1:0]   quot,
    output fric_pkg::div_tag_t               tag_out
);

    localparam int NS = fric_pkg::DIV_STAGES;
    localparam int NW = fric_pkg::DIV_NUM_W;
    localparam int RW = fric_pkg::DIV_REM_W;
    localparam int DW = fric_pkg::DEPTH_W;

    logic                 valid_reg [NS];
    logic [NW-1:0]        num_reg   [NS];
    logic [RW-1:0]        rem_reg   [NS];
    logic [DW-1:0]        den_reg   [NS];
    fric_pkg::div_tag_t   tag_reg   [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic                 v_in;
        logic [NW-1:0]        q_in;
        logic [RW-1:0]        r_in;
        logic [DW-1:0]        d_in;
        fric_pkg::div_tag_t   t_in;
        logic [NW-1:0]        q_next;
        logic [RW-1:0]        r_next;
        logic [RW-1:0]        shifted;
        logic [RW:0]          trial;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign q_in = num;
            assign r_in = '0;
            assign d_in = den;
            assign t_in = tag_in;
        end
        else
        begin : g_rest
            assign v_in = valid_reg[s-1];
            assign q_in = num_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign d_in = den_reg[s-1];
            assign t_in = tag_reg[s-1];
        end

        // quotient bits shift into the numerator register as it empties
        always_comb
        begin
            q_next  = q_in;
            r_next  = r_in;
            shifted = '0;
            trial   = '0;
            for (int j = 0; j < fric_pkg::DIV_BITS; j++)
            begin
                shifted = {r_next[RW-2:0], q_next[NW-1]};
                trial   = {1'b0, shifted} - {2'b00, d_in};
                if (!trial[RW])
                begin
                    r_next = trial[RW-1:0];
                    q_next = {q_next[NW-2:0], 1'b1};
                end
                else
                begin
                    r_next = shifted;
                    q_next = {q_next[NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s] <= q_next;
                rem_reg[s] <= r_next;
                den_reg[s] <= d_in;
                tag_reg[s] <= t_in;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign quot      = num_reg[NS-1];
    assign tag_out   = tag_reg[NS-1];

endmodule

@@ src/fric_eval.sv @@
// pipelined evaluation of dt times the friction source term at one velocity
module fric_eval (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  fric_pkg::vel_t                       u,
    input  fric_pkg::side_t                      side_in,
    input  fric_pkg::coef_t                      coef,
    output logic                                 out_valid,
    output logic signed [fric_pkg::INC_W-1:0]    incr,
    output fric_pkg::side_t                      side_out
);

    localparam int VW = fric_pkg::VEL_W;
    localparam int PW = fric_pkg::PART_W;

    // square of the velocity
    logic                          s0_valid_reg;
    logic [fric_pkg::SQ_W-1:0]     s0_sq_reg;
    logic                          s0_neg_reg;
    fric_pkg::side_t               s0_side_reg;
    logic signed [2*VW-1:0]        sq_full;

    // times cf, in two halves
    logic                          s1_valid_reg;
    logic [fric_pkg::PP_W-1:0]     s1_lo_reg;
    logic [fric_pkg::PP_W-1:0]     s1_hi_reg;
    logic                          s1_neg_reg;
    fric_pkg::side_t               s1_side_reg;
    logic [fric_pkg::PP_W-1:0]     s1_lo_next;
    logic [fric_pkg::PP_W-1:0]     s1_hi_next;

    // divider numerator
    logic                          s2_valid_reg;
    logic [fric_pkg::DIV_NUM_W-1:0] s2_num_reg;
    logic                          s2_neg_reg;
    fric_pkg::side_t               s2_side_reg;
    logic [fric_pkg::PP_W-1:0]     a_sum;
    logic [fric_pkg::DIV_NUM_W-1:0] s2_num_next;

    logic                          d_valid;
    logic [fric_pkg::DIV_NUM_W-1:0] d_quot;
    fric_pkg::div_tag_t            d_tag;
    fric_pkg::div_tag_t            d_tag_in;

    // acceleration with gravity term
    logic                          s3_valid_reg;
    logic signed [fric_pkg::ACC_W-1:0] s3_acc_reg;
    fric_pkg::side_t               s3_side_reg;
    logic signed [fric_pkg::ACC_W-1:0] gs_ext;
    logic signed [fric_pkg::ACC_W-1:0] f_ext;
    logic signed [fric_pkg::ACC_W-1:0] s3_acc_next;

    // clamped magnitude
    logic                          s4_valid_reg;
    logic [fric_pkg::MAG_W-1:0]    s4_mag_reg;
    logic                          s4_neg_reg;
    fric_pkg::side_t               s4_side_reg;
    fric_pkg::side_t               s4_side_next;
    logic [fric_pkg::ACC_W-1:0]    acc_abs;
    logic                          acc_over;
    logic [fric_pkg::MAG_W-1:0]    s4_mag_next;

    // times dt, in two halves
    logic                          s5_valid_reg;
    logic [fric_pkg::PP_W-1:0]     s5_lo_reg;
    logic [fric_pkg::PP_W-1:0]     s5_hi_reg;
    logic                          s5_neg_reg;
    fric_pkg::side_t               s5_side_reg;
    logic [fric_pkg::PP_W-1:0]     s5_lo_next;
    logic [fric_pkg::PP_W-1:0]     s5_hi_next;

    logic                          s6_valid_reg;
    logic [fric_pkg::MAG_W-1:0]    s6_mag_reg;
    logic                          s6_neg_reg;
    fric_pkg::side_t               s6_side_reg;
    logic [fric_pkg::PP_W-1:0]     d_sum;

    logic                          s7_valid_reg;
    logic signed [fric_pkg::INC_W-1:0] s7_incr_reg;
    fric_pkg::side_t               s7_side_reg;
    logic signed [fric_pkg::INC_W-1:0] s7_incr_next;

    assign sq_full = (2*VW)'(u) * (2*VW)'(u);

    assign s1_lo_next = fric_pkg::PP_W'(s0_sq_reg) * fric_pkg::PP_W'(coef.cf[PW-1:0]);
    assign s1_hi_next = fric_pkg::PP_W'(s0_sq_reg) * fric_pkg::PP_W'(coef.cf[2*PW-1:PW]);

    assign a_sum       = s1_hi_reg + (s1_lo_reg >> PW);
    assign s2_num_next = fric_pkg::DIV_NUM_W'({a_sum[fric_pkg::PP_W-1:PW],
                                               {fric_pkg::FRIC_SHIFT{1'b0}}});

    assign d_tag_in = '{side: s2_side_reg, neg: s2_neg_reg};

    fric_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .num       (s2_num_reg),
        .den       (s2_side_reg.depth),
        .tag_in    (d_tag_in),
        .out_valid (d_valid),
        .quot      (d_quot),
        .tag_out   (d_tag)
    );

    // friction opposes the motion
    assign gs_ext      = fric_pkg::ACC_W'(coef.gs);
    assign f_ext       = $signed(fric_pkg::ACC_W'(d_quot[fric_pkg::F_W-1:0]));
    assign s3_acc_next = d_tag.neg ? (gs_ext + f_ext) : (gs_ext - f_ext);

    assign acc_abs     = s3_acc_reg[fric_pkg::ACC_W-1] ? fric_pkg::ACC_W'(-s3_acc_reg)
                                                       : fric_pkg::ACC_W'(s3_acc_reg);
    assign acc_over    = |acc_abs[fric_pkg::ACC_W-1:fric_pkg::MAG_W];
    assign s4_mag_next = acc_over ? fric_pkg::ACC_LIM : acc_abs[fric_pkg::MAG_W-1:0];

    always_comb
    begin
        s4_side_next     = s3_side_reg;
        s4_side_next.sat = s3_side_reg.sat | acc_over;
    end

    assign s5_lo_next = fric_pkg::PP_W'(s4_mag_reg) * fric_pkg::PP_W'(coef.dt[PW-1:0]);
    assign s5_hi_next = fric_pkg::PP_W'(s4_mag_reg) * fric_pkg::PP_W'(coef.dt[2*PW-1:PW]);

    assign d_sum = s5_hi_reg + (s5_lo_reg >> PW);

    assign s7_incr_next = s6_neg_reg ? -$signed({1'b0, s6_mag_reg})
                                     : $signed({1'b0, s6_mag_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= d_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_sq_reg   <= sq_full[fric_pkg::SQ_W-1:0];
            s0_neg_reg  <= u[VW-1];
            s0_side_reg <= side_in;

            s1_lo_reg   <= s1_lo_next;
            s1_hi_reg   <= s1_hi_next;
            s1_neg_reg  <= s0_neg_reg;
            s1_side_reg <= s0_side_reg;

            s2_num_reg  <= s2_num_next;
            s2_neg_reg  <= s1_neg_reg;
            s2_side_reg <= s1_side_reg;

            s3_acc_reg  <= s3_acc_next;
            s3_side_reg <= d_tag.side;

            s4_mag_reg  <= s4_mag_next;
            s4_neg_reg  <= s3_acc_reg[fric_pkg::ACC_W-1];
            s4_side_reg <= s4_side_next;

            s5_lo_reg   <= s5_lo_next;
            s5_hi_reg   <= s5_hi_next;
            s5_neg_reg  <= s4_neg_reg;
            s5_side_reg <= s4_side_reg;

            s6_mag_reg  <= d_sum[fric_pkg::PP_W-1:PW];
            s6_neg_reg  <= s5_neg_reg;
            s6_side_reg <= s5_side_reg;

            s7_incr_reg <= s7_incr_next;
            s7_side_reg <= s6_side_reg;
        end
    end

    assign out_valid = s7_valid_reg;
    assign incr      = s7_incr_reg;
    assign side_out  = s7_side_reg;

endmodule

@@ src/channel_friction_rk3_update.sv @@
// top level: three-stage runge-kutta bed-friction velocity update, fully pipelined
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   velocity, depth
//   out      source     out_valid / out_stall new_velocity, saturated, dry_cell
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one transaction enters per clock while no result waits on a stalled output
// the datapath is three evaluation pipelines of 21 stages each (13 of them the
// depth divider) plus five stages of stage combination and output register
// reset clears all valid bits and loads the register defaults; cfg_ready stays high
// out_stall with a result waiting freezes the whole pipeline and raises in_stall
module channel_friction_rk3_update (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [fric_pkg::VEL_W-1:0]     velocity,
    input  logic [fric_pkg::DEPTH_W-1:0]          depth,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fric_pkg::VEL_W-1:0]     new_velocity,
    output logic                                  saturated,
    output logic                                  dry_cell,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fric_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fric_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SW = fric_pkg::SUM_W;

    logic [fric_pkg::COEF_W-1:0]          cf_reg;
    logic [fric_pkg::GRAV_W-1:0]          g_reg;
    logic signed [fric_pkg::SLOPE_W-1:0]  slope_reg;
    logic [fric_pkg::COEF_W-1:0]          dt_reg;

    logic signed [fric_pkg::GPROD_W-1:0]  gprod_reg;
    logic signed [fric_pkg::GPROD_W-1:0]  gprod_next;
    logic [fric_pkg::GPROD_W-1:0]         gabs;
    logic [fric_pkg::GS_W-1:0]            gs_mag;
    logic signed [fric_pkg::GS_W-1:0]     gs_reg;
    logic signed [fric_pkg::GS_W-1:0]     gs_next;
    fric_pkg::coef_t                      coef;

    logic                                 en;
    fric_pkg::side_t                      in_side;

    logic                                 e1_valid;
    logic signed [fric_pkg::INC_W-1:0]    e1_incr;
    fric_pkg::side_t                      e1_side;
    logic                                 e2_valid;
    logic signed [fric_pkg::INC_W-1:0]    e2_incr;
    fric_pkg::side_t                      e2_side;
    logic                                 e3_valid;
    logic signed [fric_pkg::INC_W-1:0]    e3_incr;
    fric_pkg::side_t                      e3_side;

    // first stage: u1 = u0 + dt*L(u0)
    logic                                 c1_valid_reg;
    fric_pkg::side_t                      c1_side_reg;
    fric_pkg::side_t                      c1_side_next;
    fric_pkg::sat_t                       c1_sat;

    // second stage: u2 = (3u0 + u1 + dt*L(u1)) / 4
    logic                                 c2_valid_reg;
    fric_pkg::side_t                      c2_side_reg;
    fric_pkg::side_t                      c2_side_next;
    logic signed [SW-1:0]                 c2_sum;
    logic signed [SW-1:0]                 c2_bias;
    logic signed [SW-1:0]                 c2_quot;
    fric_pkg::sat_t                       c2_sat;

    // third stage: u3 = (u0 + 2u2 + 2dt*L(u2)) / 3, through c3a, c3b and the output register
    logic                                 c3a_valid_reg;
    fric_pkg::side_t                      c3a_side_reg;
    logic [fric_pkg::DIV3_IN_W-1:0]       c3a_mag_reg;
    logic                                 c3a_neg_reg;
    logic                                 c3a_hi_reg;
    logic                                 c3a_lo_reg;
    logic signed [SW-1:0]                 c3_sum;
    logic [SW-1:0]                        c3_abs;

    logic                                 c3b_valid_reg;
    fric_pkg::side_t                      c3b_side_reg;
    logic [fric_pkg::VEL_W-1:0]           c3b_quot_reg;
    logic                                 c3b_neg_reg;
    logic                                 c3b_hi_reg;
    logic                                 c3b_lo_reg;
    logic [fric_pkg::DIV3_PROD_W-1:0]     c3_prod;

    logic                                 out_valid_reg;
    logic signed [fric_pkg::VEL_W-1:0]    new_velocity_reg;
    logic                                 saturated_reg;
    logic                                 dry_cell_reg;
    logic signed [fric_pkg::VEL_W:0]      c3_signed;
    logic signed [fric_pkg::VEL_W-1:0]    new_velocity_next;
    logic                                 saturated_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cf_reg    <= fric_pkg::CF_RESET;
            g_reg     <= fric_pkg::G_RESET;
            slope_reg <= fric_pkg::SLOPE_RESET;
            dt_reg    <= fric_pkg::DT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fric_pkg::REG_FRICTION_COEFF: cf_reg    <= cfg_data;
                fric_pkg::REG_GRAVITY:        g_reg     <= cfg_data[fric_pkg::GRAV_W-1:0];
                fric_pkg::REG_BED_SLOPE:      slope_reg <= cfg_data[fric_pkg::SLOPE_W-1:0];
                fric_pkg::REG_TIME_STEP:      dt_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // g*So is constant between writes, kept in two registers
    assign gprod_next = fric_pkg::GPROD_W'($signed({1'b0, g_reg}))
                        * fric_pkg::GPROD_W'(slope_reg);
    assign gabs       = gprod_reg[fric_pkg::GPROD_W-1] ? fric_pkg::GPROD_W'(-gprod_reg)
                                                       : fric_pkg::GPROD_W'(gprod_reg);
    assign gs_mag     = gabs[fric_pkg::GS_SHIFT +: fric_pkg::GS_W];
    assign gs_next    = gprod_reg[fric_pkg::GPROD_W-1] ? -$signed(gs_mag) : $signed(gs_mag);

    always_ff @(posedge clk)
    begin
        gprod_reg <= gprod_next;
        gs_reg    <= gs_next;
    end

    assign coef = '{cf: cf_reg, dt: dt_reg, gs: gs_reg};

    // pipeline moves unless a result waits on a stalled output
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign in_side = '{u0: velocity, u1: '0, u2: '0, depth: depth,
                       sat: 1'b0, dry: (depth == '0)};

    fric_eval u_eval1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .u         (velocity),
        .side_in   (in_side),
        .coef      (coef),
        .out_valid (e1_valid),
        .incr      (e1_incr),
        .side_out  (e1_side)
    );

    always_comb
    begin
        c1_sat          = fric_pkg::sat_vel(SW'(e1_side.u0) + SW'(e1_incr));
        c1_side_next    = e1_side;
        c1_side_next.u1 = c1_sat.v;
        c1_side_next.sat = e1_side.sat | c1_sat.sat;
    end

    fric_eval u_eval2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid_reg),
        .u         (c1_side_reg.u1),
        .side_in   (c1_side_reg),
        .coef      (coef),
        .out_valid (e2_valid),
        .incr      (e2_incr),
        .side_out  (e2_side)
    );

    // division by four truncates toward zero
    always_comb
    begin
        c2_sum  = (SW'(e2_side.u0) <<< 1) + SW'(e2_side.u0) + SW'(e2_side.u1)
                  + SW'(e2_incr);
        c2_bias = c2_sum + (c2_sum[SW-1] ? SW'(3) : SW'(0));
        c2_quot = c2_bias >>> 2;
        c2_sat  = fric_pkg::sat_vel(c2_quot);
        c2_side_next     = e2_side;
        c2_side_next.u2  = c2_sat.v;
        c2_side_next.sat = e2_side.sat | c2_sat.sat;
    end

    fric_eval u_eval3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid_reg),
        .u         (c2_side_reg.u2),
        .side_in   (c2_side_reg),
        .coef      (coef),
        .out_valid (e3_valid),
        .incr      (e3_incr),
        .side_out  (e3_side)
    );

    assign c3_sum  = SW'(e3_side.u0) + (SW'(e3_side.u2) <<< 1) + (SW'(e3_incr) <<< 1);
    assign c3_abs  = c3_sum[SW-1] ? SW'(-c3_sum) : SW'(c3_sum);
    assign c3_prod = fric_pkg::DIV3_PROD_W'(c3a_mag_reg) * fric_pkg::DIV3_PROD_W'(fric_pkg::RECIP3);

    // out-of-range quotients are caught on the dividend, the magnitude is unused then
    assign c3_signed = c3b_neg_reg ? -$signed({1'b0, c3b_quot_reg})
                                   : $signed({1'b0, c3b_quot_reg});

    always_comb
    begin
        if (c3b_side_reg.dry)
        begin
            new_velocity_next = '0;
            saturated_next    = 1'b0;
        end
        else if (c3b_hi_reg)
        begin
            new_velocity_next = fric_pkg::VEL_MAX;
            saturated_next    = 1'b1;
        end
        else if (c3b_lo_reg)
        begin
            new_velocity_next = fric_pkg::VEL_MIN;
            saturated_next    = 1'b1;
        end
        else
        begin
            new_velocity_next = c3_signed[fric_pkg::VEL_W-1:0];
            saturated_next    = c3b_side_reg.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            c3a_valid_reg <= 1'b0;
            c3b_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg  <= e1_valid;
            c2_valid_reg  <= e2_valid;
            c3a_valid_reg <= e3_valid;
            c3b_valid_reg <= c3a_valid_reg;
            out_valid_reg <= c3b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_side_reg <= c1_side_next;
            c2_side_reg <= c2_side_next;

            c3a_side_reg <= e3_side;
            c3a_mag_reg  <= c3_abs[fric_pkg::DIV3_IN_W-1:0];
            c3a_neg_reg  <= c3_sum[SW-1];
            c3a_hi_reg   <= (c3_sum >= fric_pkg::DIV3_HI);
            c3a_lo_reg   <= (c3_sum <= fric_pkg::DIV3_LO);

            c3b_side_reg <= c3a_side_reg;
            c3b_quot_reg <= c3_prod[fric_pkg::RECIP3_SHIFT +: fric_pkg::VEL_W];
            c3b_neg_reg  <= c3a_neg_reg;
            c3b_hi_reg   <= c3a_hi_reg;
            c3b_lo_reg   <= c3a_lo_reg;

            new_velocity_reg <= new_velocity_next;
            saturated_reg    <= saturated_next;
            dry_cell_reg     <= c3b_side_reg.dry;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_velocity = new_velocity_reg;
    assign saturated    = saturated_reg;
    assign dry_cell     = dry_cell_reg;

endmodule

@@ src/fric_checker.sv @@
// port-level checks of the bed-friction update, bound to the top level
`include "assert_macros.svh"

module fric_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [fric_pkg::VEL_W-1:0]  new_velocity,
    input logic                               saturated,
    input logic                               dry_cell,
    input logic                               cfg_valid,
    input logic                               cfg_ready
);

    `FRIC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(new_velocity) && $stable(saturated) && $stable(dry_cell), "stalled result changed")

    `FRIC_ASSERT(a_dry_zero, out_valid && dry_cell, new_velocity == '0 && !saturated, "dry result not zero")

    `FRIC_ASSERT(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

    `FRIC_ASSERT(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

endmodule

bind channel_friction_rk3_update fric_checker u_fric_checker (.*);
